[hw/rtl/tcs_pkg.sv]
// Package for the transposed convolution scatter unit: sizes, codes, types
// and the saturating adder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tcs_pkg;
    localparam int IN_PLANES   = 16;
    localparam int OUT_PLANES  = 16;
    localparam int MAX_KERNEL  = 8;
    localparam int MAX_OUT_DIM = 64;
    localparam int MAX_IN_DIM  = 64;

    localparam int IP_W     = $clog2(IN_PLANES);
    localparam int OP_W     = $clog2(OUT_PLANES);
    localparam int TAP_W    = $clog2(MAX_KERNEL);
    localparam int DIM_W    = $clog2(MAX_OUT_DIM);
    localparam int WADDR_W  = IP_W + OP_W + 2 * TAP_W;
    localparam int OADDR_W  = OP_W + 2 * DIM_W;
    localparam int ACC_W    = 32;
    localparam int VAL_W    = 16;

    localparam logic [2:0] MODE_WEIGHT = 3'd0;
    localparam logic [2:0] MODE_BIAS   = 3'd1;
    localparam logic [2:0] MODE_SAMPLE = 3'd2;
    localparam logic [2:0] MODE_READ   = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    localparam logic [2:0] CFG_STEP_X     = 3'd0;
    localparam logic [2:0] CFG_STEP_Y     = 3'd1;
    localparam logic [2:0] CFG_PAD_W      = 3'd2;
    localparam logic [2:0] CFG_PAD_H      = 3'd3;
    localparam logic [2:0] CFG_KERNEL_W   = 3'd4;
    localparam logic [2:0] CFG_KERNEL_H   = 3'd5;
    localparam logic [2:0] CFG_OUT_WIDTH  = 3'd6;
    localparam logic [2:0] CFG_OUT_HEIGHT = 3'd7;

    typedef struct packed {
        logic [3:0] step_x;
        logic [3:0] step_y;
        logic [2:0] pad_w;
        logic [2:0] pad_h;
        logic [3:0] kernel_w;
        logic [3:0] kernel_h;
        logic [6:0] out_width;
        logic [6:0] out_height;
    } t_cfg;

    // returns {clip, saturated sum}
    function automatic logic [ACC_W:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return {1'b1, s[ACC_W], {(ACC_W-1){~s[ACC_W]}}};
        end
        return {1'b0, s[ACC_W-1:0]};
    endfunction
endpackage
`default_nettype wire

[hw/rtl/tcs_if.sv]
// Channel interfaces of the scatter unit: item input, result output, config.
// Depends on tcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tcs_in_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        mode;
    logic [tcs_pkg::IP_W-1:0]          in_plane;
    logic [tcs_pkg::OP_W-1:0]          out_plane;
    logic [5:0]                        row;
    logic [5:0]                        col;
    logic [2:0]                        tap_row;
    logic [2:0]                        tap_col;
    logic signed [tcs_pkg::VAL_W-1:0]  value;
    modport source (output valid, mode, in_plane, out_plane, row, col, tap_row, tap_col,
                    value, input ready);
    modport sink (input valid, mode, in_plane, out_plane, row, col, tap_row, tap_col,
                  value, output ready);
endinterface

interface tcs_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [tcs_pkg::ACC_W-1:0]  out_value;
    logic                              saturated;
    modport source (output valid, out_value, saturated, input ready);
    modport sink (input valid, out_value, saturated, output ready);
endinterface

interface tcs_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [6:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/transposed_conv2d_scatter_unit.sv]
// Top level of the transposed convolution scatter unit: configuration
// registers and the engine. Depends on tcs_pkg, tcs_if, tcs_engine.
//
// Usage:
//   i_item   : valid/ready item channel; mode selects load weight, load bias,
//              input sample, read output or clear outputs.
//   o_result : valid/ready result channel; one transaction per read item.
//   i_cfg    : valid/ready register write channel, always ready; write only
//              while the block is idle.
// Item handling:
//   Load weight, load bias: written as the item is accepted; stays idle.
//   Sample: one kernel tap per cycle through the accumulator memory
//           read-modify-write pipeline for every output plane, then a drain.
//   Read: via RDWAIT and RDOUT to the output register; waits if it is full.
//   Clear: one accumulator entry per cycle over the whole memory.
// Reset: a sweep zeroes the weight and accumulator memories;
//   no item is accepted during it. Config writes are taken at any time.
// Stall: a pending result holds in the output register; the next item is
// still taken, and only a further read waits for the register to free.
`timescale 1ns / 1ps
`default_nettype none
module transposed_conv2d_scatter_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcs_in_if.sink    i_item,
    tcs_out_if.source o_result,
    tcs_cfg_if.sink   i_cfg
);
    tcs_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_x     <= 4'd1;
            r_cfg.step_y     <= 4'd1;
            r_cfg.pad_w      <= 3'd0;
            r_cfg.pad_h      <= 3'd0;
            r_cfg.kernel_w   <= 4'd3;
            r_cfg.kernel_h   <= 4'd3;
            r_cfg.out_width  <= 7'd8;
            r_cfg.out_height <= 7'd8;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tcs_pkg::CFG_STEP_X:     r_cfg.step_x     <= i_cfg.data[3:0];
                tcs_pkg::CFG_STEP_Y:     r_cfg.step_y     <= i_cfg.data[3:0];
                tcs_pkg::CFG_PAD_W:      r_cfg.pad_w      <= i_cfg.data[2:0];
                tcs_pkg::CFG_PAD_H:      r_cfg.pad_h      <= i_cfg.data[2:0];
                tcs_pkg::CFG_KERNEL_W:   r_cfg.kernel_w   <= i_cfg.data[3:0];
                tcs_pkg::CFG_KERNEL_H:   r_cfg.kernel_h   <= i_cfg.data[3:0];
                tcs_pkg::CFG_OUT_WIDTH:  r_cfg.out_width  <= i_cfg.data;
                tcs_pkg::CFG_OUT_HEIGHT: r_cfg.out_height <= i_cfg.data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    tcs_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (i_item),
        .o_result (o_result)
    );
endmodule
`default_nettype wire

[hw/rtl/tcs_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tcs_ram #(
    parameter int WIDTH = 16,
    parameter int AW    = 14
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[hw/rtl/tcs_engine.sv]
// Sequencer of the scatter unit: weight and accumulator memories, scatter
// pipeline, read path and clearing sweeps. Depends on tcs_pkg, tcs_if, tcs_ram.
`timescale 1ns / 1ps
`default_nettype none
module tcs_engine (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tcs_pkg::t_cfg  i_cfg,
    tcs_in_if.sink              i_item,
    tcs_out_if.source           o_result
);
    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAT   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_RDWAIT = 3'd4;
    localparam logic [2:0] ST_RDOUT  = 3'd5;
    localparam logic [2:0] ST_CLEAR  = 3'd6;

    localparam int OW = tcs_pkg::ACC_W + 1;

    logic [2:0]                    r_state, n_state;
    logic [tcs_pkg::OADDR_W-1:0]   r_cnt, n_cnt;
    logic [tcs_pkg::OP_W-1:0]      r_p, n_p;
    logic [tcs_pkg::TAP_W-1:0]     r_i, n_i, r_j, n_j;
    logic [tcs_pkg::IP_W-1:0]      r_ip;
    logic signed [tcs_pkg::VAL_W-1:0] r_sample;
    logic signed [11:0]            r_base_r, r_base_c;
    logic [tcs_pkg::OP_W-1:0]      r_op;
    logic                          r_rd_ok;
    logic signed [tcs_pkg::VAL_W-1:0] r_bias [tcs_pkg::OUT_PLANES];

    logic                          r_s1_v, r_s2_v;
    logic [tcs_pkg::OADDR_W-1:0]   r_s1_oaddr, r_s2_oaddr;
    logic signed [tcs_pkg::ACC_W-1:0] r_s2_prod;
    logic [tcs_pkg::ACC_W-1:0]     r_s2_acc;
    logic                          r_s2_mark;

    logic                          r_out_v;
    logic [tcs_pkg::ACC_W-1:0]     r_out_value;
    logic                          r_out_sat;

    logic [3:0]  kh_e, kw_e;
    logic [6:0]  oh_e, ow_e;
    logic        accept, tap_in, last_i, last_j, out_free;
    logic signed [11:0] y, x;
    logic [tcs_pkg::OADDR_W-1:0] tap_oaddr;
    logic [tcs_pkg::ACC_W:0]     s2_sum, rd_sum;
    logic [tcs_pkg::ACC_W-1:0]   bias_ext;
    logic [9:0]  prod_r, prod_c;

    logic                          w_we, w_re, o_we, o_re;
    logic [tcs_pkg::WADDR_W-1:0]   w_waddr, w_raddr;
    logic [tcs_pkg::VAL_W-1:0]     w_wdata, w_rdata;
    logic [tcs_pkg::OADDR_W-1:0]   o_waddr, o_raddr;
    logic [OW-1:0]                 o_wdata, o_rdata;

    tcs_ram #(.WIDTH(tcs_pkg::VAL_W), .AW(tcs_pkg::WADDR_W)) u_wram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_re(w_re), .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    tcs_ram #(.WIDTH(OW), .AW(tcs_pkg::OADDR_W)) u_oram (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_waddr), .i_wdata(o_wdata),
        .i_re(o_re), .i_raddr(o_raddr), .o_rdata(o_rdata)
    );

    assign kh_e = (i_cfg.kernel_h > 4'(tcs_pkg::MAX_KERNEL)) ? 4'(tcs_pkg::MAX_KERNEL)
                                                             : i_cfg.kernel_h;
    assign kw_e = (i_cfg.kernel_w > 4'(tcs_pkg::MAX_KERNEL)) ? 4'(tcs_pkg::MAX_KERNEL)
                                                             : i_cfg.kernel_w;
    assign oh_e = (i_cfg.out_height > 7'(tcs_pkg::MAX_OUT_DIM)) ? 7'(tcs_pkg::MAX_OUT_DIM)
                                                                : i_cfg.out_height;
    assign ow_e = (i_cfg.out_width > 7'(tcs_pkg::MAX_OUT_DIM)) ? 7'(tcs_pkg::MAX_OUT_DIM)
                                                               : i_cfg.out_width;

    assign i_item.ready = (r_state == ST_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign out_free     = !r_out_v || o_result.ready;

    assign prod_r = i_item.row * i_cfg.step_y;
    assign prod_c = i_item.col * i_cfg.step_x;

    assign y = r_base_r + $signed({9'b0, r_i});
    assign x = r_base_c + $signed({9'b0, r_j});
    assign tap_in = !y[11] && (y < $signed({5'b0, oh_e})) &&
                    !x[11] && (x < $signed({5'b0, ow_e}));
    assign tap_oaddr = {r_p, y[tcs_pkg::DIM_W-1:0], x[tcs_pkg::DIM_W-1:0]};
    assign last_i = ({1'b0, r_i} == kh_e - 4'd1);
    assign last_j = ({1'b0, r_j} == kw_e - 4'd1);

    assign s2_sum   = tcs_pkg::sat_add(r_s2_acc, r_s2_prod);
    assign bias_ext = {{8{r_bias[r_op][tcs_pkg::VAL_W-1]}}, r_bias[r_op], 8'b0};
    assign rd_sum   = tcs_pkg::sat_add(o_rdata[tcs_pkg::ACC_W-1:0], bias_ext);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = {i_item.in_plane, i_item.out_plane, i_item.tap_row, i_item.tap_col};
        w_wdata = i_item.value;
        if (r_state == ST_INIT) begin
            w_we    = (r_cnt[tcs_pkg::OADDR_W-1:tcs_pkg::WADDR_W] == '0);
            w_waddr = r_cnt[tcs_pkg::WADDR_W-1:0];
            w_wdata = '0;
        end else if (accept && i_item.mode == tcs_pkg::MODE_WEIGHT) begin
            w_we = 1'b1;
        end
        w_re    = (r_state == ST_SCAT);
        w_raddr = {r_ip, r_p, r_i, r_j};

        if (r_state == ST_INIT || r_state == ST_CLEAR) begin
            o_we    = 1'b1;
            o_waddr = r_cnt;
            o_wdata = '0;
        end else begin
            o_we    = r_s2_v;
            o_waddr = r_s2_oaddr;
            o_wdata = {r_s2_mark | s2_sum[tcs_pkg::ACC_W], s2_sum[tcs_pkg::ACC_W-1:0]};
        end
        o_re    = (r_state == ST_SCAT) || (accept && i_item.mode == tcs_pkg::MODE_READ);
        o_raddr = (r_state == ST_SCAT) ? tap_oaddr
                                       : {i_item.out_plane, i_item.row, i_item.col};
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_p     = r_p;
        n_i     = r_i;
        n_j     = r_j;
        case (r_state)
            ST_INIT, ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_item.mode)
                        tcs_pkg::MODE_SAMPLE: begin
                            n_p = '0;
                            n_i = '0;
                            n_j = '0;
                            if (kh_e != 4'd0 && kw_e != 4'd0) begin
                                n_state = ST_SCAT;
                            end
                        end
                        tcs_pkg::MODE_READ: n_state = ST_RDWAIT;
                        tcs_pkg::MODE_CLEAR: begin
                            n_cnt   = '0;
                            n_state = ST_CLEAR;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAT: begin
                n_j = r_j + 1'b1;
                if (last_j) begin
                    n_j = '0;
                    n_i = r_i + 1'b1;
                    if (last_i) begin
                        n_i = '0;
                        n_p = r_p + 1'b1;
                        if (&r_p) begin
                            n_state = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (!r_s1_v && !r_s2_v) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RDWAIT: n_state = ST_RDOUT;
            ST_RDOUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cnt   <= '0;
            r_p     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
            for (int k = 0; k < tcs_pkg::OUT_PLANES; k++) begin
                r_bias[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_p     <= n_p;
            r_i     <= n_i;
            r_j     <= n_j;
            r_s1_v  <= (r_state == ST_SCAT) && tap_in;
            r_s2_v  <= r_s1_v;
            if (accept && i_item.mode == tcs_pkg::MODE_BIAS) begin
                r_bias[i_item.out_plane] <= i_item.value;
            end
            if (r_state == ST_RDOUT && out_free) begin
                r_out_v <= 1'b1;
            end else if (o_result.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ip     <= i_item.in_plane;
            r_sample <= i_item.value;
            r_base_r <= $signed({2'b0, prod_r}) - $signed({9'b0, i_cfg.pad_h});
            r_base_c <= $signed({2'b0, prod_c}) - $signed({9'b0, i_cfg.pad_w});
            r_op     <= i_item.out_plane;
            r_rd_ok  <= ({1'b0, i_item.row} < oh_e) && ({1'b0, i_item.col} < ow_e);
        end
        r_s1_oaddr <= tap_oaddr;
        r_s2_oaddr <= r_s1_oaddr;
        r_s2_prod  <= r_sample * $signed(w_rdata);
        r_s2_acc   <= o_rdata[tcs_pkg::ACC_W-1:0];
        r_s2_mark  <= o_rdata[tcs_pkg::ACC_W];
        if (r_state == ST_RDOUT && out_free) begin
            r_out_value <= r_rd_ok ? rd_sum[tcs_pkg::ACC_W-1:0] : '0;
            r_out_sat   <= r_rd_ok && (rd_sum[tcs_pkg::ACC_W] || o_rdata[tcs_pkg::ACC_W]);
        end
    end

    assign o_result.valid     = r_out_v;
    assign o_result.out_value = r_out_value;
    assign o_result.saturated = r_out_sat;

    a_s2_follows_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> $past(r_s1_v))
        else $error("accumulate stage without a preceding tap");
    a_no_acc_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INIT || r_state == ST_CLEAR) |-> !r_s1_v && !r_s2_v)
        else $error("accumulator write during clearing sweep");
    a_drained_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_s2_v)
        else $error("pipeline still busy when new item may enter");
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(r_state) == ST_RDOUT)
        else $error("result produced outside read path");
endmodule
`default_nettype wire

[verif/transposed_conv2d_scatter_unit_tb.sv]
// Testbench for transposed_conv2d_scatter_unit: directed and random item
// streams checked against an in-bench scatter/accumulate predictor.
// Depends on tcs_pkg, tcs_if and the unit itself.
`timescale 1ns / 1ps
module transposed_conv2d_scatter_unit_tb;
    localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] MODE_UNUSED_MID   = 3'd6;
    localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]         mode;
        logic [3:0]         ip;
        logic [3:0]         op;
        logic [5:0]         row;
        logic [5:0]         col;
        logic [2:0]         tr;
        logic [2:0]         tc;
        logic signed [15:0] value;
    } t_conv_cmd;

    typedef struct {
        int sum;
        bit sat;
    } t_read_val;

    logic i_clk;
    logic i_rst_n;

    tcs_in_if  item_if ();
    tcs_out_if res_if ();
    tcs_cfg_if cfg_if ();

    transposed_conv2d_scatter_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    // predictor state, zero at start
    tcs_pkg::t_cfg      geom;
    bit signed [15:0]   weight_mem [16384];
    bit signed [15:0]   bias_mem [16];
    int                 acc_mem [65536];
    bit                 clip_mem [65536];

    t_conv_cmd cmd_q [$];
    t_read_val read_q [$];
    t_conv_cmd cur_cmd;
    bit        offering;
    int        send_gap;
    int        hold_left;
    int        errors = 0;
    int        reads_seen = 0;
    int        samples_taken = 0;
    int        clears_taken = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp_acc(input longint s, output bit clip);
        clip = 1'b0;
        if (s > 64'sd2147483647) begin
            clip = 1'b1;
            return 32'h7fffffff;
        end
        if (s < -64'sd2147483648) begin
            clip = 1'b1;
            return 32'h80000000;
        end
        return int'(s);
    endfunction

    function automatic int eff_dim(input int v, input int lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic void scatter_sample(input t_conv_cmd c);
        int  kh, kw, oh, ow, base_r, base_c, y, x;
        int  idx;
        bit  clip;
        kh = eff_dim(geom.kernel_h, tcs_pkg::MAX_KERNEL);
        kw = eff_dim(geom.kernel_w, tcs_pkg::MAX_KERNEL);
        oh = eff_dim(geom.out_height, tcs_pkg::MAX_OUT_DIM);
        ow = eff_dim(geom.out_width, tcs_pkg::MAX_OUT_DIM);
        base_r = int'(c.row) * int'(geom.step_y) - int'(geom.pad_h);
        base_c = int'(c.col) * int'(geom.step_x) - int'(geom.pad_w);
        for (int p = 0; p < tcs_pkg::OUT_PLANES; p++) begin
            for (int i = 0; i < kh; i++) begin
                y = base_r + i;
                if (y < 0 || y >= oh) continue;
                for (int j = 0; j < kw; j++) begin
                    x = base_c + j;
                    if (x < 0 || x >= ow) continue;
                    idx = (p * tcs_pkg::MAX_OUT_DIM + y) * tcs_pkg::MAX_OUT_DIM + x;
                    acc_mem[idx] = clamp_acc(longint'(acc_mem[idx]) + longint'(c.value)
                        * longint'(weight_mem[{c.ip, p[3:0], i[2:0], j[2:0]}]), clip);
                    if (clip) clip_mem[idx] = 1'b1;
                end
            end
        end
    endfunction

    function automatic void apply_cmd(input t_conv_cmd c);
        t_read_val rv;
        int        idx;
        bit        clip;
        case (c.mode)
            tcs_pkg::MODE_WEIGHT: weight_mem[{c.ip, c.op, c.tr, c.tc}] = c.value;
            tcs_pkg::MODE_BIAS:   bias_mem[c.op] = c.value;
            tcs_pkg::MODE_SAMPLE: scatter_sample(c);
            tcs_pkg::MODE_READ: begin
                rv.sum = 0;
                rv.sat = 1'b0;
                if (c.row < eff_dim(geom.out_height, tcs_pkg::MAX_OUT_DIM) &&
                    c.col < eff_dim(geom.out_width, tcs_pkg::MAX_OUT_DIM)) begin
                    idx = (int'(c.op) * tcs_pkg::MAX_OUT_DIM + c.row) * tcs_pkg::MAX_OUT_DIM
                          + c.col;
                    rv.sum = clamp_acc(longint'(acc_mem[idx]) + longint'(bias_mem[c.op]) * 256,
                                       clip);
                    rv.sat = clip | clip_mem[idx];
                end
                read_q.push_back(rv);
            end
            tcs_pkg::MODE_CLEAR: begin
                foreach (acc_mem[k]) begin
                    acc_mem[k] = 0;
                    clip_mem[k] = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            offering = 1'b0;
            send_gap = 0;
            cur_cmd = '0;
            item_if.valid     <= 1'b0;
            item_if.mode      <= tcs_pkg::MODE_WEIGHT;
            item_if.in_plane  <= '0;
            item_if.out_plane <= '0;
            item_if.row       <= '0;
            item_if.col       <= '0;
            item_if.tap_row   <= '0;
            item_if.tap_col   <= '0;
            item_if.value     <= '0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                apply_cmd(cur_cmd);
                if (cur_cmd.mode == tcs_pkg::MODE_SAMPLE) samples_taken++;
                if (cur_cmd.mode == tcs_pkg::MODE_CLEAR) clears_taken++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (cmd_q.size() > 0) begin
                    cur_cmd = cmd_q.pop_front();
                    offering = 1'b1;
                    send_gap = draw_gap();
                end
            end
            item_if.valid     <= offering;
            item_if.mode      <= cur_cmd.mode;
            item_if.in_plane  <= cur_cmd.ip;
            item_if.out_plane <= cur_cmd.op;
            item_if.row       <= cur_cmd.row;
            item_if.col       <= cur_cmd.col;
            item_if.tap_row   <= cur_cmd.tr;
            item_if.tap_col   <= cur_cmd.tc;
            item_if.value     <= cur_cmd.value;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_read_val ev;
        if (!i_rst_n) begin
            hold_left = 0;
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                reads_seen++;
                if (read_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result value %0d sat %0b", $time,
                             res_if.out_value, res_if.saturated);
                end else begin
                    ev = read_q.pop_front();
                    if (res_if.out_value !== ev.sum) begin
                        errors++;
                        $display("%0t: out_value expected %0d actual %0d", $time, ev.sum,
                                 res_if.out_value);
                    end
                    if (res_if.saturated !== ev.sat) begin
                        errors++;
                        $display("%0t: saturated expected %0b actual %0b", $time, ev.sat,
                                 res_if.saturated);
                    end
                end
                // hold off long enough for the unit to back up its input
                if (reads_seen == 40 || reads_seen == 220) hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 70) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
            end
        end
    end

    function automatic t_conv_cmd mk_cmd(input logic [2:0] mode, input int ip, input int op,
                                         input int row, input int col, input int tr,
                                         input int tc, input int value);
        t_conv_cmd c;
        c.mode  = mode;
        c.ip    = 4'(ip);
        c.op    = 4'(op);
        c.row   = 6'(row);
        c.col   = 6'(col);
        c.tr    = 3'(tr);
        c.tc    = 3'(tc);
        c.value = 16'(value);
        return c;
    endfunction

    function automatic int rand_value();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535);
        return int'($urandom_range(0, 1023)) - 512;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input int data);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= 7'(data);
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            tcs_pkg::CFG_STEP_X:     geom.step_x     = 4'(data);
            tcs_pkg::CFG_STEP_Y:     geom.step_y     = 4'(data);
            tcs_pkg::CFG_PAD_W:      geom.pad_w      = 3'(data);
            tcs_pkg::CFG_PAD_H:      geom.pad_h      = 3'(data);
            tcs_pkg::CFG_KERNEL_W:   geom.kernel_w   = 4'(data);
            tcs_pkg::CFG_KERNEL_H:   geom.kernel_h   = 4'(data);
            tcs_pkg::CFG_OUT_WIDTH:  geom.out_width  = 7'(data);
            tcs_pkg::CFG_OUT_HEIGHT: geom.out_height = 7'(data);
            default: ;
        endcase
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_geometry(input int sx, input int sy, input int pw, input int ph,
                                input int kw, input int kh, input int ow, input int oh);
        write_reg(tcs_pkg::CFG_STEP_X, sx);
        write_reg(tcs_pkg::CFG_STEP_Y, sy);
        write_reg(tcs_pkg::CFG_PAD_W, pw);
        write_reg(tcs_pkg::CFG_PAD_H, ph);
        write_reg(tcs_pkg::CFG_KERNEL_W, kw);
        write_reg(tcs_pkg::CFG_KERNEL_H, kh);
        write_reg(tcs_pkg::CFG_OUT_WIDTH, ow);
        write_reg(tcs_pkg::CFG_OUT_HEIGHT, oh);
    endtask

    // let the queue and every outstanding read drain
    task automatic drain();
        while (cmd_q.size() > 0 || offering || read_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic queue_phase(input bit with_clear, output int n);
        int oh, ow, rmax;
        n = 0;
        oh = eff_dim(geom.out_height, tcs_pkg::MAX_OUT_DIM);
        ow = eff_dim(geom.out_width, tcs_pkg::MAX_OUT_DIM);
        if (with_clear) begin
            cmd_q.push_back(mk_cmd(tcs_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
            n++;
        end
        for (int k = 0; k < 56; k++) begin
            int sel;
            sel = $urandom_range(0, 99);
            rmax = (geom.step_y == 0) ? 63 : eff_dim(oh / geom.step_y + 2, 63);
            if (sel < 16) begin
                cmd_q.push_back(mk_cmd(tcs_pkg::MODE_WEIGHT, $urandom_range(0, 15),
                                       $urandom_range(0, 15), 0, 0, $urandom_range(0, 7),
                                       $urandom_range(0, 7), rand_value()));
            end else if (sel < 20) begin
                cmd_q.push_back(mk_cmd(tcs_pkg::MODE_BIAS, $urandom_range(0, 15),
                                       $urandom_range(0, 15), $urandom_range(0, 63),
                                       $urandom_range(0, 63), 0, 0, rand_value()));
            end else if (sel < 55) begin
                if ($urandom_range(0, 4) == 0)
                    cmd_q.push_back(mk_cmd(tcs_pkg::MODE_SAMPLE, $urandom_range(0, 15), 0,
                                           $urandom_range(0, 63), $urandom_range(0, 63), 0, 0,
                                           rand_value()));
                else
                    cmd_q.push_back(mk_cmd(tcs_pkg::MODE_SAMPLE, $urandom_range(0, 3), 0,
                                           $urandom_range(0, rmax), $urandom_range(0, rmax), 0, 0,
                                           rand_value()));
            end else if (sel < 97 || oh == 0 || ow == 0) begin
                if ($urandom_range(0, 4) == 0 || oh == 0 || ow == 0)
                    cmd_q.push_back(mk_cmd(tcs_pkg::MODE_READ, 0, $urandom_range(0, 15),
                                           $urandom_range(0, 63), $urandom_range(0, 63), 0, 0, 0));
                else
                    cmd_q.push_back(mk_cmd(tcs_pkg::MODE_READ, 0, $urandom_range(0, 15),
                                           $urandom_range(0, oh - 1), $urandom_range(0, ow - 1),
                                           0, 0, 0));
            end else begin
                cmd_q.push_back(mk_cmd(3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)),
                                       $urandom_range(0, 15), $urandom_range(0, 15),
                                       $urandom_range(0, 63), $urandom_range(0, 63),
                                       $urandom_range(0, 7), $urandom_range(0, 7), rand_value()));
            end
            n++;
        end
        // close with a read so its arrival marks the unit idle
        cmd_q.push_back(mk_cmd(tcs_pkg::MODE_READ, 0, $urandom_range(0, 15), 0, 0, 0, 0, 0));
        n++;
    endtask

    initial begin
        int total, n, phase;
        cfg_if.valid = 1'b0;
        cfg_if.index = tcs_pkg::CFG_STEP_X;
        cfg_if.data = '0;
        geom = '{step_x: 1, step_y: 1, pad_w: 0, pad_h: 0, kernel_w: 3, kernel_h: 3,
                 out_width: 8, out_height: 8};
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: saturation both ways, bias clip, extremes, unused modes
        cmd_q.push_back(mk_cmd(tcs_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(mk_cmd(tcs_pkg::MODE_WEIGHT, 0, 0, 0, 0, 0, 0, -32768));
        cmd_q.push_back(mk_cmd(tcs_pkg::MODE_WEIGHT, 15, 15, 0, 0, 7, 7, 32767));
        cmd_q.push_back(mk_cmd(tcs_pkg::MODE_WEIGHT, 1, 1, 0, 0, 1, 1, 32767));
        cmd_q.push_back(mk_cmd(tcs_pkg::MODE_BIAS, 0, 0, 0, 0, 0, 0, 32767));
        cmd_q.push_back(mk_cmd(tcs_pkg::MODE_BIAS, 0, 15, 0, 0, 0, 0, -32768));
        repeat (3) cmd_q.push_back(mk_cmd(tcs_pkg::MODE_SAMPLE, 0, 0, 0, 0, 0, 0, -32768));
        repeat (3) cmd_q.push_back(mk_cmd(tcs_pkg::MODE_SAMPLE, 1, 0, 1, 1, 0, 0, -32768));
        cmd_q.push_back(mk_cmd(tcs_pkg::MODE_SAMPLE, 15, 0, 63, 63, 0, 0, 32767));
        cmd_q.push_back(mk_cmd(tcs_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(mk_cmd(tcs_pkg::MODE_READ, 0, 1, 2, 2, 0, 0, 0));
        cmd_q.push_back(mk_cmd(tcs_pkg::MODE_READ, 0, 15, 7, 7, 0, 0, 0));
        cmd_q.push_back(mk_cmd(tcs_pkg::MODE_READ, 0, 15, 63, 63, 0, 0, 0));
        cmd_q.push_back(mk_cmd(MODE_UNUSED_FIRST, 15, 15, 63, 63, 7, 7, -1));
        cmd_q.push_back(mk_cmd(MODE_UNUSED_MID, 0, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(mk_cmd(MODE_UNUSED_LAST, 5, 10, 21, 42, 3, 4, 12345));
        cmd_q.push_back(mk_cmd(tcs_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(mk_cmd(tcs_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0));
        cmd_q.push_back(mk_cmd(tcs_pkg::MODE_READ, 0, 1, 2, 2, 0, 0, 0));
        total = 23;
        drain();

        phase = 0;
        while (total < 580) begin
            case (phase)
                0: set_geometry(1, 1, 0, 0, 3, 3, 8, 8);
                1: set_geometry(8, 8, 7, 7, 8, 8, 64, 64);
                2: set_geometry(1, 1, 0, 0, 1, 1, 1, 1);
                3: set_geometry(15, 0, 7, 3, 15, 2, 127, 100);
                4: set_geometry(2, 3, 1, 2, 0, 4, 0, 16);
                default: set_geometry($urandom_range(1, 8), $urandom_range(1, 8),
                                      $urandom_range(0, 7), $urandom_range(0, 7),
                                      $urandom_range(1, 4), $urandom_range(1, 4),
                                      $urandom_range(1, 64), $urandom_range(1, 64));
            endcase
            queue_phase(phase % 3 == 1, n);
            total += n;
            drain();
            phase++;
        end

        $display("Covered %0d items over %0d geometry settings: %0d samples, %0d clears,",
                 total, phase, samples_taken, clears_taken);
        $display("%0d reads checked, two long result stalls, saturation and edge cropping.",
                 reads_seen);
        if (errors == 0) begin
            $display("transposed_conv2d_scatter_unit test passed");
        end else begin
            $display("transposed_conv2d_scatter_unit test failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("transposed_conv2d_scatter_unit test failed");
        $finish;
    end
endmodule

[transposed_conv2d_scatter_unit.f]
hw/rtl/tcs_pkg.sv
hw/rtl/tcs_if.sv
hw/rtl/tcs_ram.sv
hw/rtl/tcs_engine.sv
hw/rtl/transposed_conv2d_scatter_unit.sv
verif/transposed_conv2d_scatter_unit_tb.sv
